@@ hdl/tlr_pkg.sv @@
package tlr_pkg;

  // Line orientation: major axis and direction of the minor axis
  typedef enum logic [1:0] {
    OCT_X_UP   = 2'd0,
    OCT_X_DOWN = 2'd1,
    OCT_Y_RIGHT = 2'd2,
    OCT_Y_LEFT  = 2'd3
  } octant_t;

  // Item kinds carried on in_tuser
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // Configuration register indexes
  localparam logic CFG_SHIFT_X = 1'b0;
  localparam logic CFG_SHIFT_Y = 1'b1;

  localparam int unsigned COLOR_BITS = 24;

endpackage

@@ hdl/translated_line_rasterizer_core.sv @@
// Translated line rasterizer: walks a line between two endpoints one pixel
// per step item, using the integer midpoint (Bresenham) decision variable.
//
// Channels:
//   cfg_*  : register writes (index 0 = shift_x, 1 = shift_y), always ready.
//            Write only while the block is idle.
//   in_*   : items. in_tuser = 0 starts a line (endpoints + color in tdata,
//            translated by shift_x/shift_y); in_tuser = 1 asks for the next
//            pixel. A start gives no result, a step while idle gives none.
//   out_*  : one pixel per step item, out_tlast set on the line's final pixel.
// Path: a step item is held in the input register, then execute writes its
//   pixel into the result register, or into the skid register while that is full.
// Throughput: one item per cycle while the skid entry is free; the execute stage
//   is one add and compare on the decision variable, or the setup arithmetic for a start.
// Stall: a two-entry result buffer (result register plus skid register)
//   keeps in_tready high while the skid entry is free; once the skid entry
//   is full, hold the input register and drop in_tready.
// Reset: synchronous active-low rst_n clears shifts, the line state (idle)
//   and all valid flags.
module translated_line_rasterizer_core
  import tlr_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // configuration write channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic                    cfg_index,
  input  logic [COORD_BITS-1:0]   cfg_data,
  // input channel
  input  logic                    in_tvalid,
  output logic                    in_tready,
  // tdata from bit 0: start_x, start_y, end_x, end_y, color, zero pad
  input  logic [((4*COORD_BITS+COLOR_BITS+7)/8)*8-1:0] in_tdata,
  // tuser: command
  input  logic                    in_tuser,
  // result channel
  output logic                    out_tvalid,
  input  logic                    out_tready,
  // tdata from bit 0: pixel_x, pixel_y, pixel_color, zero pad
  output logic [((2*COORD_BITS+2+COLOR_BITS+7)/8)*8-1:0] out_tdata,
  output logic                    out_tlast
);

  localparam int unsigned CW    = COORD_BITS + 1;   // translated coordinate
  localparam int unsigned DLW   = COORD_BITS + 2;   // endpoint difference
  localparam int unsigned DW    = COORD_BITS + 4;   // decision variable
  localparam int unsigned OUT_W = ((2*CW+COLOR_BITS+7)/8)*8;
  localparam int unsigned OPAD  = OUT_W - 2*CW - COLOR_BITS;

  // ---------------------------------------------------------------- config
  logic signed [COORD_BITS-1:0] shift_x_r, shift_y_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_x_r <= '0;
      shift_y_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_SHIFT_X) shift_x_r <= $signed(cfg_data);
      if (cfg_index == CFG_SHIFT_Y) shift_y_r <= $signed(cfg_data);
    end
  end

  // ----------------------------------------------------------- input stage
  logic signed [COORD_BITS-1:0] f_sx, f_sy, f_ex, f_ey;
  logic [COLOR_BITS-1:0]        f_color;

  assign f_sx    = $signed(in_tdata[COORD_BITS-1:0]);
  assign f_sy    = $signed(in_tdata[2*COORD_BITS-1:COORD_BITS]);
  assign f_ex    = $signed(in_tdata[3*COORD_BITS-1:2*COORD_BITS]);
  assign f_ey    = $signed(in_tdata[4*COORD_BITS-1:3*COORD_BITS]);
  assign f_color = in_tdata[4*COORD_BITS+COLOR_BITS-1:4*COORD_BITS];

  logic                 s1_valid_r;
  logic                 s1_cmd_r;
  logic signed [CW-1:0] s1_ax_r, s1_ay_r, s1_bx_r, s1_by_r;
  logic [COLOR_BITS-1:0] s1_color_r;

  logic skid_valid_r;
  logic exec_fire;

  // Execute runs whenever the skid entry is free, so a result always has room
  assign exec_fire = s1_valid_r && !skid_valid_r;
  assign in_tready = !s1_valid_r || exec_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  // Translate both endpoints on the way in
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_cmd_r   <= in_tuser;
      s1_ax_r    <= {f_sx[COORD_BITS-1], f_sx} + {shift_x_r[COORD_BITS-1], shift_x_r};
      s1_ay_r    <= {f_sy[COORD_BITS-1], f_sy} + {shift_y_r[COORD_BITS-1], shift_y_r};
      s1_bx_r    <= {f_ex[COORD_BITS-1], f_ex} + {shift_x_r[COORD_BITS-1], shift_x_r};
      s1_by_r    <= {f_ey[COORD_BITS-1], f_ey} + {shift_y_r[COORD_BITS-1], shift_y_r};
      s1_color_r <= f_color;
    end
  end

  // ---------------------------------------------------------- line state
  logic signed [CW-1:0]  cur_x_r, cur_y_r, major_end_r;
  logic signed [DW-1:0]  decision_r, keep_r, move_r;
  octant_t               octant_r;
  logic                  active_r;
  logic [COLOR_BITS-1:0] line_color_r;

  // Start setup: order the endpoints along the major axis
  logic signed [DLW-1:0] dx, dy, adx, ady, major_d, minor_d;
  logic                  x_major, swap, minor_up;
  logic signed [DW-1:0]  maj_w, min_w;
  logic signed [DW-1:0]  start_decision, start_keep, start_move;
  logic signed [CW-1:0]  start_x, start_y, start_end;
  octant_t               start_octant;

  always_comb begin
    dx      = {s1_bx_r[CW-1], s1_bx_r} - {s1_ax_r[CW-1], s1_ax_r};
    dy      = {s1_by_r[CW-1], s1_by_r} - {s1_ay_r[CW-1], s1_ay_r};
    adx     = dx[DLW-1] ? -dx : dx;
    ady     = dy[DLW-1] ? -dy : dy;
    x_major = adx >= ady;
    swap    = x_major ? (s1_ax_r > s1_bx_r) : (s1_ay_r > s1_by_r);
    // Minor axis direction after ordering
    if (x_major) begin
      minor_up = swap ? (dy <= 0) : (dy >= 0);
    end else begin
      minor_up = swap ? (dx <= 0) : (dx >= 0);
    end
    major_d = x_major ? adx : ady;
    minor_d = x_major ? ady : adx;
    maj_w   = {{(DW-DLW){major_d[DLW-1]}}, major_d};
    min_w   = {{(DW-DLW){minor_d[DLW-1]}}, minor_d};
    start_decision = maj_w - (min_w + min_w);
    start_keep     = -(min_w + min_w);
    start_move     = (maj_w - min_w) + (maj_w - min_w);
    start_x        = swap ? s1_bx_r : s1_ax_r;
    start_y        = swap ? s1_by_r : s1_ay_r;
    if (x_major) begin
      start_end    = swap ? s1_ax_r : s1_bx_r;
      start_octant = minor_up ? OCT_X_UP : OCT_X_DOWN;
    end else begin
      start_end    = swap ? s1_ay_r : s1_by_r;
      start_octant = minor_up ? OCT_Y_RIGHT : OCT_Y_LEFT;
    end
  end

  // Step: emit the current pixel, then advance one pixel along the major axis
  logic                 is_last, emit;
  logic signed [CW-1:0] step_x_nxt, step_y_nxt;
  logic signed [DW-1:0] step_dec_nxt;

  assign is_last = ((octant_r == OCT_X_UP) || (octant_r == OCT_X_DOWN))
                   ? (cur_x_r >= major_end_r) : (cur_y_r >= major_end_r);
  assign emit    = exec_fire && (s1_cmd_r == CMD_STEP) && active_r;

  always_comb begin
    step_x_nxt   = cur_x_r;
    step_y_nxt   = cur_y_r;
    step_dec_nxt = decision_r + move_r;
    case (octant_r)
      OCT_X_UP, OCT_X_DOWN: begin
        step_x_nxt = cur_x_r + CW'(1);
        if (decision_r > 0) begin
          step_dec_nxt = decision_r + keep_r;
        end else begin
          step_y_nxt = (octant_r == OCT_X_UP) ? cur_y_r + CW'(1) : cur_y_r - CW'(1);
        end
      end
      OCT_Y_RIGHT: begin
        step_y_nxt = cur_y_r + CW'(1);
        if (decision_r >= 0) begin
          step_dec_nxt = decision_r + keep_r;
        end else begin
          step_x_nxt = cur_x_r + CW'(1);
        end
      end
      default: begin
        step_y_nxt = cur_y_r + CW'(1);
        if (decision_r > 0) begin
          step_dec_nxt = decision_r + keep_r;
        end else begin
          step_x_nxt = cur_x_r - CW'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r      <= '0;
      cur_y_r      <= '0;
      major_end_r  <= '0;
      decision_r   <= '0;
      keep_r       <= '0;
      move_r       <= '0;
      octant_r     <= OCT_X_UP;
      active_r     <= 1'b0;
      line_color_r <= '0;
    end else if (exec_fire) begin
      if (s1_cmd_r == CMD_START) begin
        // A start replaces any line in progress
        cur_x_r      <= start_x;
        cur_y_r      <= start_y;
        major_end_r  <= start_end;
        decision_r   <= start_decision;
        keep_r       <= start_keep;
        move_r       <= start_move;
        octant_r     <= start_octant;
        active_r     <= 1'b1;
        line_color_r <= s1_color_r;
      end else if (active_r) begin
        if (is_last) begin
          active_r <= 1'b0;
        end else begin
          cur_x_r    <= step_x_nxt;
          cur_y_r    <= step_y_nxt;
          decision_r <= step_dec_nxt;
        end
      end
    end
  end

  // --------------------------------------------------------- result buffer
  logic [OUT_W-1:0] new_data;
  logic [OUT_W-1:0] out_data_r, skid_data_r;
  logic             out_last_r, skid_last_r;
  logic             out_valid_r;
  logic             pop;

  assign new_data = {{OPAD{1'b0}}, line_color_r, cur_y_r, cur_x_r};
  assign pop      = out_valid_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop) begin
      // Skid entry, when present, is older than a new result
      if (skid_valid_r) begin
        skid_valid_r <= emit;
      end else begin
        out_valid_r <= emit;
      end
    end else if (emit) begin
      if (out_valid_r) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
        out_last_r <= skid_last_r;
        if (emit) begin
          skid_data_r <= new_data;
          skid_last_r <= is_last;
        end
      end else if (emit) begin
        out_data_r <= new_data;
        out_last_r <= is_last;
      end
    end else if (emit) begin
      if (out_valid_r) begin
        skid_data_r <= new_data;
        skid_last_r <= is_last;
      end else begin
        out_data_r <= new_data;
        out_last_r <= is_last;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // ------------------------------------------------------------ assertions
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while result register empty");

  a_emit_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> !skid_valid_r)
    else $error("result produced with no buffer space");

  a_skid_moves_up: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && skid_valid_r) |=> out_valid_r)
    else $error("skid entry lost on drain");

  a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && is_last) |=> !active_r)
    else $error("line still active after final pixel");

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import tlr_pkg::*;

  localparam int IN_W  = 72;  // start_x, start_y, end_x, end_y, color
  localparam int OUT_W = 56;  // pixel_x, pixel_y, pixel_color, zero pad
  localparam int N_PHASES = 6;
  localparam int RANDOM_ITEMS = 1400;
  localparam int SETTLE_CYCLES = 6;  // two-stage pipe plus skid, with margin

  // One pixel as it leaves the block
  typedef struct {
    logic signed [12:0] x;
    logic signed [12:0] y;
    logic [23:0]        color;
    logic               last;
  } pixel_t;

  // Midpoint line walker kept in step with the block. It predicts the pixel
  // for every accepted step item on an active line and checks pixels as they come out.
  class line_scoreboard;
    logic signed [11:0] shift_x;
    logic signed [11:0] shift_y;
    logic signed [12:0] cur_x;
    logic signed [12:0] cur_y;
    logic signed [12:0] major_end;
    logic signed [15:0] decision;
    logic signed [15:0] step_keep;
    logic signed [15:0] step_move;
    octant_t            octant;
    logic               line_active;
    logic [23:0]        line_color;
    pixel_t             pending_pixels[$];
    int                 failures;
    int                 reported;

    function new();
      shift_x = '0;
      shift_y = '0;
      cur_x = '0;
      cur_y = '0;
      major_end = '0;
      decision = '0;
      step_keep = '0;
      step_move = '0;
      octant = OCT_X_UP;
      line_active = 1'b0;
      line_color = '0;
      failures = 0;
      reported = 0;
    endfunction

    function void write_reg(logic idx, logic [11:0] value);
      if (idx == CFG_SHIFT_X) shift_x = value;
      else shift_y = value;
    endfunction

    function int outstanding();
      return pending_pixels.size();
    endfunction

    function void note_item(logic cmd, logic [IN_W-1:0] data);
      int ax, ay, bx, by, dx, dy, adx, ady, t;
      pixel_t px;
      logic at_end;
      if (cmd == CMD_START) begin
        ax = int'($signed(data[11:0])) + int'(shift_x);
        ay = int'($signed(data[23:12])) + int'(shift_y);
        bx = int'($signed(data[35:24])) + int'(shift_x);
        by = int'($signed(data[47:36])) + int'(shift_y);
        dx = bx - ax;
        dy = by - ay;
        adx = dx < 0 ? -dx : dx;
        ady = dy < 0 ? -dy : dy;
        if (adx >= ady) begin
          if (ax > bx) begin
            t = ax; ax = bx; bx = t;
            t = ay; ay = by; by = t;
            dx = -dx; dy = -dy;
          end
          octant = dy >= 0 ? OCT_X_UP : OCT_X_DOWN;
          decision = 16'(dx - 2 * ady);
          step_keep = 16'(-2 * ady);
          step_move = 16'(2 * (dx - ady));
          major_end = 13'(bx);
        end else begin
          if (ay > by) begin
            t = ax; ax = bx; bx = t;
            t = ay; ay = by; by = t;
            dx = -dx; dy = -dy;
          end
          octant = dx >= 0 ? OCT_Y_RIGHT : OCT_Y_LEFT;
          decision = 16'(dy - 2 * adx);
          step_keep = 16'(-2 * adx);
          step_move = 16'(2 * (dy - adx));
          major_end = 13'(by);
        end
        cur_x = 13'(ax);
        cur_y = 13'(ay);
        line_color = data[71:48];
        line_active = 1'b1;
      end else if (line_active) begin
        if (octant == OCT_X_UP || octant == OCT_X_DOWN) at_end = cur_x >= major_end;
        else at_end = cur_y >= major_end;
        px.x = cur_x;
        px.y = cur_y;
        px.color = line_color;
        px.last = at_end;
        pending_pixels.push_back(px);
        if (at_end) begin
          line_active = 1'b0;
        end else begin
          case (octant)
            OCT_X_UP, OCT_X_DOWN: begin
              cur_x = cur_x + 13'sd1;
              if (decision > 0) begin
                decision = decision + step_keep;
              end else begin
                cur_y = (octant == OCT_X_UP) ? cur_y + 13'sd1 : cur_y - 13'sd1;
                decision = decision + step_move;
              end
            end
            // ties keep the major-only step when y is major and x rises
            OCT_Y_RIGHT: begin
              cur_y = cur_y + 13'sd1;
              if (decision >= 0) begin
                decision = decision + step_keep;
              end else begin
                cur_x = cur_x + 13'sd1;
                decision = decision + step_move;
              end
            end
            default: begin
              cur_y = cur_y + 13'sd1;
              if (decision > 0) begin
                decision = decision + step_keep;
              end else begin
                cur_x = cur_x - 13'sd1;
                decision = decision + step_move;
              end
            end
          endcase
        end
      end
    endfunction

    function void flag(string what, int want, int got);
      failures++;
      if (reported < 10) begin
        reported++;
        $display("  mismatch %0s: expected %0d, got %0d", what, want, got);
      end
    endfunction

    function void check_pixel(logic [OUT_W-1:0] data, logic last);
      pixel_t want;
      pixel_t got;
      got.x = data[12:0];
      got.y = data[25:13];
      got.color = data[49:26];
      got.last = last;
      if (pending_pixels.size() == 0) begin
        flag("unexpected pixel, x", 0, got.x);
        return;
      end
      want = pending_pixels.pop_front();
      if (got.x != want.x) flag("pixel_x", want.x, got.x);
      if (got.y != want.y) flag("pixel_y", want.y, got.y);
      if (got.color != want.color) flag("pixel_color", want.color, got.color);
      if (got.last != want.last) flag("last", want.last, got.last);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_index;
  logic [11:0] cfg_data;
  logic in_tvalid;
  logic in_tready;
  logic [IN_W-1:0] in_tdata;   // start_x, start_y, end_x, end_y, color
  logic in_tuser;              // command
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata; // pixel_x, pixel_y, pixel_color, zero pad
  logic out_tlast;

  line_scoreboard sb = new();
  int items_sent;
  int send_idle;   // percent of cycles the sender holds back
  int recv_idle;   // percent of cycles the receiver stalls

  translated_line_rasterizer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #2 clk = ~clk;

  // Drop out_tready at random on the falling edge to stall the result side
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // Sample both handshakes at the rising edge; predict on input, check on output
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_item(in_tuser, in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_pixel(out_tdata, out_tlast);
  end

  // Hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [IN_W-1:0] line_data(int sx, int sy, int ex, int ey,
                                                logic [23:0] color);
    return {color, 12'(ey), 12'(ex), 12'(sy), 12'(sx)};
  endfunction

  function automatic logic [IN_W-1:0] noise_data();
    return IN_W'({$urandom, $urandom, $urandom});
  endfunction

  // Offset a coordinate, mirroring or redrawing it if it leaves the range
  function automatic int fit_coord(int base, int offset);
    int v;
    v = base + offset;
    if (v > 2047 || v < -2048) v = base - offset;
    if (v > 2047 || v < -2048) v = $urandom_range(0, 4095) - 2048;
    return v;
  endfunction

  // Call at a falling edge; returns at the falling edge after acceptance
  // with in_tvalid still high, so the next call sets it exactly once.
  task automatic drive_item(logic cmd, logic [IN_W-1:0] data);
    while ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= data;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic draw_line(int sx, int sy, int ex, int ey, logic [23:0] color,
                           int steps);
    drive_item(CMD_START, line_data(sx, sy, ex, ey, color));
    repeat (steps) drive_item(CMD_STEP, noise_data());
  endtask

  // Hold the input side until every predicted pixel has come out
  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  // Write one shift register; call only with the block idle
  task automatic write_shift(logic idx, logic [11:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, value);
    @(negedge clk);
  endtask

  task automatic set_shifts(int sx, int sy);
    write_shift(CFG_SHIFT_X, 12'(sx));
    write_shift(CFG_SHIFT_Y, 12'(sy));
    cfg_valid <= 1'b0;
  endtask

  // One line with random placement: mostly short and walked to its end,
  // sometimes overstepped while idle or cut short by the next start.
  task automatic random_line();
    int sx, sy, ex, ey, span, len, steps, pick;
    pick = $urandom_range(0, 99);
    span = pick < 80 ? 12 : (pick < 95 ? 150 : 4095);
    sx = $urandom_range(0, 4095) - 2048;
    sy = $urandom_range(0, 4095) - 2048;
    ex = fit_coord(sx, $urandom_range(0, 2 * span) - span);
    ey = fit_coord(sy, $urandom_range(0, 2 * span) - span);
    len = ((ex > sx ? ex - sx : sx - ex) > (ey > sy ? ey - sy : sy - ey) ?
           (ex > sx ? ex - sx : sx - ex) : (ey > sy ? ey - sy : sy - ey)) + 1;
    pick = $urandom_range(0, 99);
    if (pick < 70) steps = len;
    else if (pick < 85) steps = len + $urandom_range(1, 3);
    else steps = $urandom_range(0, len - 1);
    if (steps > 200) steps = $urandom_range(1, 200);
    draw_line(sx, sy, ex, ey, 24'($urandom), steps);
  endtask

  task automatic directed_lines();
    // step with no line in progress
    drive_item(CMD_STEP, noise_data());
    // single-point line
    draw_line(3, -3, 3, -3, 24'h5a5a5a, 1);
    // each octant, endpoints given backward where the walk swaps them,
    // each with a zero decision on the first step to hit the tie rules
    draw_line(2, 1, 0, 0, 24'hffffff, 3);
    draw_line(0, 0, 2, -1, 24'h123456, 3);
    draw_line(0, 0, 1, 2, 24'habcdef, 3);
    draw_line(-1, 2, 0, 0, 24'h800001, 3);
    // full-range diagonal, replaced by the next start while active
    draw_line(-2048, -2048, 2047, 2047, 24'h000000, 2);
    draw_line(2047, -2048, 2047, -2048, 24'h7fffff, 1);
  endtask

  // Coordinate extremes under the current shifts
  task automatic edge_lines();
    draw_line(2047, 2047, 2045, 2046, 24'hffffff, 3);
    draw_line(-2048, -2048, -2047, -2046, 24'h000000, 3);
  endtask

  initial begin
    int target;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    in_tvalid = 1'b0;
    in_tuser = 1'b0;
    in_tdata = '0;
    items_sent = 0;
    send_idle = 20;
    recv_idle = 77;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int phase = 0; phase < N_PHASES; phase++) begin
      // sender sparse and receiver busy, then swapped, then full speed
      send_idle = phase < 2 ? 20 : (phase < 4 ? 77 : 0);
      recv_idle = phase < 2 ? 77 : (phase < 4 ? 20 : 0);
      case (phase)
        0: set_shifts(0, 0);
        1: set_shifts(2047, -2048);
        2: set_shifts(-2048, 2047);
        3: set_shifts($urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048);
        4: set_shifts(2047, 2047);
        default: set_shifts(-2048, -2048);
      endcase
      if (phase == 0) directed_lines();
      edge_lines();

      target = items_sent + RANDOM_ITEMS / N_PHASES;
      while (items_sent < target) begin
        if ($urandom_range(0, 99) < 5) drive_item(1'($urandom_range(0, 1)), noise_data());
        else random_line();
        // now and then let the result side run dry mid-phase
        if ($urandom_range(0, 39) == 0) drain();
      end

      // close any open line with a single point so the shifts can change
      if (sb.line_active) draw_line(0, 0, 0, 0, 24'($urandom), 1);
      drain();
      repeat (SETTLE_CYCLES) @(negedge clk);
    end

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
